/* hw/rtl/tts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants
// Payload structs, sequencer states and arithmetic widths for the
// triangle tangent space unit.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned VertexSlotsDefault = 1024;
  localparam int unsigned SlotW = 10;
  localparam int unsigned DivQW = 34;   // quotient bits kept before saturation

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_CORNER = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [SlotW-1:0]   vertex_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   corner_a;
    logic [SlotW-1:0]   corner_b;
    logic [SlotW-1:0]   corner_c;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CAP2,
    ST_DET,
    ST_NUM,
    ST_DIV,
    ST_DIVWAIT,
    ST_OUT
  } seq_state_e;

  // divider command and status between sequencer and divider
  typedef struct packed {
    logic               start;
    logic signed [36:0] num;
    logic signed [36:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } div_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tts_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_divider: radix-2 restoring divider
// Computes round(num * 2^22 / den), ties away from zero, saturated to int32.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tts_divider (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tts_pkg::div_cmd_t   cmd_i,
  output tts_pkg::div_sts_t   sts_o
);

  localparam int unsigned QW = tts_pkg::DivQW;
  localparam int unsigned NW = 36 + 22 + 1;   // |num| << 22, plus rounding

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NW-1:0]   dvd_q, dvd_d;
  logic [36:0]     rem_q, rem_d;
  logic [35:0]     den_q, den_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [31:0]     res_q, res_d;

  logic [35:0] an, ad;
  logic [37:0] trial;
  logic [36:0] rsh;

  always_comb begin
    an = cmd_i.num[36] ? 36'(-cmd_i.num) : cmd_i.num[35:0];
    ad = cmd_i.den[36] ? 36'(-cmd_i.den) : cmd_i.den[35:0];
    rsh = {rem_q[35:0], dvd_q[NW-1]};
    trial = {1'b0, rsh} - {2'b00, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d = neg_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    res_d = res_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      neg_d = cmd_i.num[36] ^ cmd_i.den[36];
      dvd_d = {1'b0, an, 22'd0} + NW'(ad >> 1);
      rem_d = '0;
      den_d = ad;
      quo_d = '0;
      cnt_d = 6'(NW);
    end else if (busy_q) begin
      dvd_d = {dvd_q[NW-2:0], 1'b0};
      if (!trial[37]) begin
        rem_d = trial[36:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = rsh;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (done_q) begin
      // saturate; quo_q holds the low QW bits, quotients never exceed 2^58
      if (neg_q) begin
        res_d = (quo_q > QW'(33'h80000000)) ? 32'h80000000 : 32'(-quo_q);
      end else begin
        res_d = (quo_q > QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_q[31:0];
      end
    end
  end

  // overflow beyond QW bits is tracked by a sticky flag
  logic ovf_q, ovf_d;
  always_comb begin
    ovf_d = ovf_q;
    if (cmd_i.start) ovf_d = 1'b0;
    else if (busy_q && quo_q[QW-1]) ovf_d = 1'b1;
  end

  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      fin_q  <= done_q;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    res_q <= ovf_q ? (neg_q ? 32'h80000000 : 32'h7FFFFFFF) : res_d;
  end

  assign sts_o.busy = busy_q | done_q;
  assign sts_o.done = fin_q;
  assign sts_o.quot = res_q;

endmodule

`default_nettype wire

/* hw/rtl/triangle_tangent_space.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_space: per-triangle tangent and bitangent
// Vertex store plus sequencer; the third corner triggers the reads, the
// UV determinant, six numerators and, unless it is zero, six serial divisions.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                payload
//  in       in   in_valid_i/in_stall_o    tts_pkg::in_item_t
//  out      out  out_valid_o/out_stall_i  tts_pkg::out_item_t
//
// Loads and first/second corners do not start the sequencer. A third corner
// occupies the unit until its result is registered: six passes of the bit-serial
// divider (start, 59 quotient bits, round/saturate, hand-off) dominate. Degenerate
// triangles skip division.
// Reset clears the corner count and sequencer; the store is undefined until
// written. A stalled result holds in the output register; the next item is
// taken while it waits, but a new triangle waits for the register.
// ----------------------------------------------------------------------------
module triangle_tangent_space #(
  parameter int unsigned VERTEX_SLOTS = tts_pkg::VertexSlotsDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  tts_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output tts_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

  logic [79:0] mem [VERTEX_SLOTS];
  logic [79:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  tts_pkg::seq_state_e st_q, st_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hc0_q, hc1_q, hc2_q;
  logic        ok0_q, ok1_q, ok2_q;
  logic signed [15:0] v0_q [5], v1_q [5];
  logic signed [16:0] e1_q [3], e2_q [3];
  logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [36:0] det_q;
  logic signed [36:0] num_q [6];
  logic signed [31:0] vec_q [6];
  logic [2:0]  k_q, k_d;
  logic        ovld_q;

  logic in_acc, corner_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign corner_acc = in_acc && (in_data_i.action == tts_pkg::ACT_CORNER);

  // busy while a triangle is in flight; a third corner also needs the
  // output register free
  assign in_stall_o = (st_q != tts_pkg::ST_IDLE) ||
                      (in_data_i.action == tts_pkg::ACT_CORNER && cnt_q == 2'd2 &&
                       ovld_q);

  logic slot_ok;
  assign slot_ok = 32'(in_data_i.vertex_slot) < VERTEX_SLOTS;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == tts_pkg::ACT_LOAD && slot_ok)
      mem[AW'(in_data_i.vertex_slot)] <= {in_data_i.pos_x, in_data_i.pos_y,
                                          in_data_i.pos_z, in_data_i.tex_u,
                                          in_data_i.tex_v};
    if (rd_en) rd_q <= mem[rd_addr];
  end

  tts_pkg::div_cmd_t dcmd;
  tts_pkg::div_sts_t dsts;
  tts_divider u_div (.clk_i, .rst_ni, .cmd_i(dcmd), .sts_o(dsts));

  function automatic logic signed [15:0] fld(input logic [79:0] w, input int i);
    fld = w[79-16*i -: 16];
  endfunction

  logic signed [15:0] cur [5];
  always_comb begin
    for (int i = 0; i < 5; i++) cur[i] = fld(rd_q, i);
  end

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    k_d = k_q;
    rd_en = 1'b0;
    rd_addr = AW'(hc0_q);
    dcmd.start = 1'b0;
    dcmd.num = num_q[k_q];
    dcmd.den = det_q;
    case (st_q)
      tts_pkg::ST_IDLE: begin
        if (corner_acc) begin
          if (cnt_q == 2'd2) begin
            cnt_d = 2'd0;
            st_d = tts_pkg::ST_RD0;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      tts_pkg::ST_RD0: begin
        rd_en = 1'b1; rd_addr = AW'(hc0_q); st_d = tts_pkg::ST_RD1;
      end
      tts_pkg::ST_RD1: begin
        rd_en = 1'b1; rd_addr = AW'(hc1_q); st_d = tts_pkg::ST_RD2;
      end
      tts_pkg::ST_RD2: begin
        rd_en = 1'b1; rd_addr = AW'(hc2_q); st_d = tts_pkg::ST_CAP2;
      end
      tts_pkg::ST_CAP2: st_d = tts_pkg::ST_DET;
      tts_pkg::ST_DET:  st_d = tts_pkg::ST_NUM;
      tts_pkg::ST_NUM: begin
        k_d = 3'd0;
        st_d = (det_q == '0) ? tts_pkg::ST_OUT : tts_pkg::ST_DIV;
      end
      tts_pkg::ST_DIV: begin
        dcmd.start = 1'b1;
        st_d = tts_pkg::ST_DIVWAIT;
      end
      tts_pkg::ST_DIVWAIT: begin
        if (dsts.done) begin
          if (k_q == 3'd5) st_d = tts_pkg::ST_OUT;
          else begin
            k_d = k_q + 3'd1;
            st_d = tts_pkg::ST_DIV;
          end
        end
      end
      tts_pkg::ST_OUT: st_d = tts_pkg::ST_IDLE;
      default: st_d = tts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tts_pkg::ST_IDLE;
      cnt_q <= 2'd0;
      hc0_q <= '0;
      hc1_q <= '0;
      k_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      k_q <= k_d;
      if (corner_acc && cnt_q == 2'd0) hc0_q <= in_data_i.vertex_slot;
      if (corner_acc && cnt_q == 2'd1) hc1_q <= in_data_i.vertex_slot;
      if (st_q == tts_pkg::ST_OUT) ovld_q <= 1'b1;
      else if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (corner_acc && cnt_q == 2'd2) begin
      hc2_q <= in_data_i.vertex_slot;
      ok2_q <= slot_ok;
    end
    if (corner_acc && cnt_q == 2'd0) ok0_q <= slot_ok;
    if (corner_acc && cnt_q == 2'd1) ok1_q <= slot_ok;
    if (st_q == tts_pkg::ST_RD1)
      for (int i = 0; i < 5; i++) v0_q[i] <= ok0_q ? cur[i] : '0;
    if (st_q == tts_pkg::ST_RD2)
      for (int i = 0; i < 5; i++) v1_q[i] <= ok1_q ? cur[i] : '0;
    if (st_q == tts_pkg::ST_CAP2) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= 17'(v1_q[i]) - 17'(v0_q[i]);
        e2_q[i] <= (ok2_q ? 17'(cur[i]) : 17'sd0) - 17'(v0_q[i]);
      end
      du1_q <= 17'(v1_q[3]) - 17'(v0_q[3]);
      dv1_q <= 17'(v1_q[4]) - 17'(v0_q[4]);
      du2_q <= (ok2_q ? 17'(cur[3]) : 17'sd0) - 17'(v0_q[3]);
      dv2_q <= (ok2_q ? 17'(cur[4]) : 17'sd0) - 17'(v0_q[4]);
    end
    if (st_q == tts_pkg::ST_DET) begin
      det_q <= 37'(du1_q * dv2_q) - 37'(du2_q * dv1_q);
      for (int i = 0; i < 3; i++) begin
        num_q[i]   <= 37'(dv2_q * e1_q[i]) - 37'(dv1_q * e2_q[i]);
        num_q[3+i] <= 37'(du1_q * e2_q[i]) - 37'(du2_q * e1_q[i]);
      end
    end
    if (st_q == tts_pkg::ST_NUM)
      for (int i = 0; i < 6; i++) vec_q[i] <= '0;
    if (st_q == tts_pkg::ST_DIVWAIT && dsts.done) vec_q[k_q] <= dsts.quot;
    if (st_q == tts_pkg::ST_OUT) begin
      out_data_o.corner_a <= hc0_q;
      out_data_o.corner_b <= hc1_q;
      out_data_o.corner_c <= hc2_q;
      out_data_o.tangent_x <= vec_q[0];
      out_data_o.tangent_y <= vec_q[1];
      out_data_o.tangent_z <= vec_q[2];
      out_data_o.bitangent_x <= vec_q[3];
      out_data_o.bitangent_y <= vec_q[4];
      out_data_o.bitangent_z <= vec_q[5];
      out_data_o.degenerate <= (det_q == '0);
    end
  end

  assign out_valid_o = ovld_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == tts_pkg::ST_OUT) |-> !ovld_q)
    else $error("result overwrites pending transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcmd.start |-> !dsts.busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != tts_pkg::ST_IDLE) |-> cnt_q == 2'd0)
    else $error("corner count not cleared for triangle");

endmodule

`default_nettype wire

/* tb/triangle_tangent_space_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tangent_space_tb: self-checking bench for the tangent space unit
// Loads vertices and submits corner triples, predicts each triangle's tangent,
// bitangent and degenerate flag, and checks results in order against it.
// ----------------------------------------------------------------------------
module triangle_tangent_space_tb;

  localparam int unsigned NumSlots = 1024;
  localparam int unsigned WatchdogLimit = 20000;

  class tangent_scoreboard;
    logic [15:0] vtx_mem [NumSlots][5];
    bit          vtx_written [NumSlots];
    int unsigned corners_held;
    logic [tts_pkg::SlotW-1:0] held_slot [2];
    tts_pkg::out_item_t expected_q[$];
    int unsigned error_count;

    function new();
      corners_held = 0;
      held_slot[0] = '0;
      held_slot[1] = '0;
      error_count = 0;
    endfunction

    function automatic longint sx(logic [15:0] v);
      return longint'($signed(v));
    endfunction

    // num * 2^22 / den, rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] fix_div(longint num, longint den);
      bit neg;
      longint unsigned an, ad, q;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = ((an << 22) + (ad >> 1)) / ad;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return 32'(-longint'(q));
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return 32'(q);
    endfunction

    function automatic void note_input(tts_pkg::in_item_t it);
      longint p [3][5];
      longint e1 [3], e2 [3], du1, dv1, du2, dv2, det;
      logic [tts_pkg::SlotW-1:0] s [3];
      logic [31:0] t [3], b [3];
      tts_pkg::out_item_t r;
      if (it.action == tts_pkg::ACT_LOAD) begin
        vtx_mem[it.vertex_slot][0] = it.pos_x;
        vtx_mem[it.vertex_slot][1] = it.pos_y;
        vtx_mem[it.vertex_slot][2] = it.pos_z;
        vtx_mem[it.vertex_slot][3] = it.tex_u;
        vtx_mem[it.vertex_slot][4] = it.tex_v;
        vtx_written[it.vertex_slot] = 1'b1;
        return;
      end
      if (corners_held < 2) begin
        held_slot[corners_held] = it.vertex_slot;
        corners_held++;
        return;
      end
      corners_held = 0;
      s[0] = held_slot[0];
      s[1] = held_slot[1];
      s[2] = it.vertex_slot;
      for (int k = 0; k < 3; k++)
        for (int f = 0; f < 5; f++) p[k][f] = sx(vtx_mem[s[k]][f]);
      for (int i = 0; i < 3; i++) begin
        e1[i] = p[1][i] - p[0][i];
        e2[i] = p[2][i] - p[0][i];
      end
      du1 = p[1][3] - p[0][3];
      dv1 = p[1][4] - p[0][4];
      du2 = p[2][3] - p[0][3];
      dv2 = p[2][4] - p[0][4];
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        if (det == 0) begin
          t[i] = '0;
          b[i] = '0;
        end else begin
          t[i] = fix_div(dv2 * e1[i] - dv1 * e2[i], det);
          b[i] = fix_div(du1 * e2[i] - du2 * e1[i], det);
        end
      end
      r.corner_a = s[0];
      r.corner_b = s[1];
      r.corner_c = s[2];
      r.tangent_x = t[0];
      r.tangent_y = t[1];
      r.tangent_z = t[2];
      r.bitangent_x = b[0];
      r.bitangent_y = b[1];
      r.bitangent_z = b[2];
      r.degenerate = (det == 0);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d actual %0d", name, e, a);
        error_count++;
      end
    endfunction

    function automatic void check_result(tts_pkg::out_item_t got);
      tts_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: corners %0d %0d %0d",
               got.corner_a, got.corner_b, got.corner_c);
        error_count++;
        return;
      end
      e = expected_q.pop_front();
      cmp("corner_a", e.corner_a, got.corner_a);
      cmp("corner_b", e.corner_b, got.corner_b);
      cmp("corner_c", e.corner_c, got.corner_c);
      cmp("tangent_x", e.tangent_x, got.tangent_x);
      cmp("tangent_y", e.tangent_y, got.tangent_y);
      cmp("tangent_z", e.tangent_z, got.tangent_z);
      cmp("bitangent_x", e.bitangent_x, got.bitangent_x);
      cmp("bitangent_y", e.bitangent_y, got.bitangent_y);
      cmp("bitangent_z", e.bitangent_z, got.bitangent_z);
      cmp("degenerate", e.degenerate, got.degenerate);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tts_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tts_pkg::out_item_t out_data_o;

  tangent_scoreboard tangent_sb = new();
  bit idle_enable = 1'b0;
  bit hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  triangle_tangent_space u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // monitor: note accepted inputs, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tangent_sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) tangent_sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        n = 0;
        out_stall_i <= 1'b1;
        while (n < 3000) begin
          @(negedge clk_i);
          n++;
        end
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= idle_enable && ($urandom_range(99) < 11);
      end
    end
  end

  // one transfer; called at a falling edge, returns at a falling edge with
  // valid still high so back-to-back items need no gap
  task automatic send_item(tts_pkg::in_item_t it);
    while (idle_enable && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic load_vertex(logic [9:0] slot, logic [15:0] px, logic [15:0] py,
                             logic [15:0] pz, logic [15:0] u, logic [15:0] v);
    tts_pkg::in_item_t it;
    it.action = tts_pkg::ACT_LOAD;
    it.vertex_slot = slot;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.tex_u = u;
    it.tex_v = v;
    send_item(it);
  endtask

  // corner items carry random junk in the unused fields
  task automatic send_corner(logic [9:0] slot);
    tts_pkg::in_item_t it;
    it.action = tts_pkg::ACT_CORNER;
    it.vertex_slot = slot;
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.pos_z = 16'($urandom);
    it.tex_u = 16'($urandom);
    it.tex_v = 16'($urandom);
    send_item(it);
  endtask

  function automatic logic [9:0] written_slot();
    logic [9:0] s;
    do s = 10'($urandom); while (!tangent_sb.vtx_written[s]);
    return s;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // drops valid, then waits for every expected result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tangent_sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, degenerate, sign cases, loads between corners
    load_vertex(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    load_vertex(10'd1, 16'h0100, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    load_vertex(10'd2, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h4000);
    load_vertex(10'd1023, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    load_vertex(10'd512, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    load_vertex(10'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000);
    send_corner(10'd0); send_corner(10'd1); send_corner(10'd2);
    send_corner(10'd0); send_corner(10'd0); send_corner(10'd0);
    send_corner(10'd1023); send_corner(10'd512); send_corner(10'd0);
    send_corner(10'd3); send_corner(10'd0);
    load_vertex(10'd2, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001);
    send_corner(10'd2);
    send_corner(10'd512); send_corner(10'd1023); send_corner(10'd3);
    wait_drained();

    // random: fill many slots, then mostly triangles with some reloads
    idle_enable = 1'b1;
    sent = 0;
    for (int i = 0; i < 200; i++) begin
      load_vertex(10'($urandom), rand_field(), rand_field(), rand_field(),
                  rand_field(), rand_field());
      sent++;
    end
    while (sent < 1050) begin
      if (sent > 300 && sent < 400) idle_enable = 1'b0;
      else idle_enable = 1'b1;
      if (sent >= 500 && sent < 503) hold_off_req = 1'b1;
      if (sent >= 700 && sent < 703) wait_drained();
      if ($urandom_range(99) < 25) begin
        load_vertex(10'($urandom), rand_field(), rand_field(), rand_field(),
                    rand_field(), rand_field());
        sent++;
      end else begin
        send_corner(written_slot());
        sent++;
      end
    end
    // complete any partial triangle
    while (tangent_sb.corners_held != 0) send_corner(written_slot());
    wait_drained();
    repeat (500) @(negedge clk_i);
    if (tangent_sb.error_count == 0 && tangent_sb.expected_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* triangle_tangent_space.f */
hw/rtl/tts_pkg.sv
hw/rtl/tts_divider.sv
hw/rtl/triangle_tangent_space.sv
tb/triangle_tangent_space_tb.sv
